@@ rtl/mur_abc_pkg.sv @@
`default_nettype none
package mur_abc_pkg;

  localparam int MaxRadius  = 63;
  localparam int SampleW    = 32;
  localparam int PosW       = 7;
  localparam int CoefW      = 16;
  localparam int RadW       = 6;
  localparam int PlaneSide  = 2 * MaxRadius + 1;
  localparam int PlaneDepth = PlaneSide * PlaneSide;
  localparam int AddrW      = $clog2(PlaneDepth);
  localparam int QDepth     = 2;
  localparam int LvlW       = $clog2(QDepth + 1);
  localparam int CfgIdxW    = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCoef   = 1'b0,
    CfgRadius = 1'b1
  } cfg_idx_t;

  typedef logic signed [SampleW-1:0] sample_t;

  // one face axis: which side (if any) and the entry on that face
  typedef struct packed {
    logic             hit;
    logic             high;
    logic [AddrW-1:0] addr;
  } face_sel_t;

  typedef struct packed {
    sample_t   ex;
    sample_t   ey;
    sample_t   ez;
    sample_t   ey_ix;
    sample_t   ez_ix;
    sample_t   ex_iy;
    sample_t   ez_iy;
    sample_t   ex_iz;
    sample_t   ey_iz;
    face_sel_t fx;
    face_sel_t fy;
    face_sel_t fz;
  } item_t;

  typedef struct packed {
    logic [LvlW-1:0] level;
    logic            full;
  } front_stat_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } back_stat_t;

endpackage
`default_nettype wire

@@ rtl/mur_abc_face_ram.sv @@
`default_nettype none
module mur_abc_face_ram (
  input  wire logic                                  clk,
  input  wire logic                                  en,
  input  wire logic                                  we,
  input  wire logic [mur_abc_pkg::AddrW-1:0]         addr,
  input  wire logic [2*mur_abc_pkg::SampleW-1:0]     wdata,
  output logic      [2*mur_abc_pkg::SampleW-1:0]     rdata
);

  logic [2*mur_abc_pkg::SampleW-1:0] mem [mur_abc_pkg::PlaneDepth];
  logic [2*mur_abc_pkg::SampleW-1:0] rdata_r;

  // read-first: a read and write at one address return the old entry
  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r <= mem[addr];
    end
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ rtl/mur_abc_front.sv @@
`default_nettype none
module mur_abc_front (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [mur_abc_pkg::PosW-1:0]    in_pos_x,
  input  wire logic signed [mur_abc_pkg::PosW-1:0]    in_pos_y,
  input  wire logic signed [mur_abc_pkg::PosW-1:0]    in_pos_z,
  input  wire mur_abc_pkg::sample_t                   in_ex_here,
  input  wire mur_abc_pkg::sample_t                   in_ey_here,
  input  wire mur_abc_pkg::sample_t                   in_ez_here,
  input  wire mur_abc_pkg::sample_t                   in_ey_inner_x,
  input  wire mur_abc_pkg::sample_t                   in_ez_inner_x,
  input  wire mur_abc_pkg::sample_t                   in_ex_inner_y,
  input  wire mur_abc_pkg::sample_t                   in_ez_inner_y,
  input  wire mur_abc_pkg::sample_t                   in_ex_inner_z,
  input  wire mur_abc_pkg::sample_t                   in_ey_inner_z,
  input  wire logic [mur_abc_pkg::RadW-1:0]           radius,
  output logic                                        head_valid,
  output mur_abc_pkg::item_t                          head,
  input  wire logic                                   pop,
  output mur_abc_pkg::front_stat_t                    stat
);

  localparam int PtrW = $clog2(mur_abc_pkg::QDepth);

  function automatic logic [mur_abc_pkg::AddrW-1:0] plane_index(
    input logic signed [mur_abc_pkg::PosW-1:0] a,
    input logic signed [mur_abc_pkg::PosW-1:0] b);
    int av;
    int bv;
    av = int'(a);
    bv = int'(b);
    if (av < -mur_abc_pkg::MaxRadius) av = -mur_abc_pkg::MaxRadius;
    if (av > mur_abc_pkg::MaxRadius)  av = mur_abc_pkg::MaxRadius;
    if (bv < -mur_abc_pkg::MaxRadius) bv = -mur_abc_pkg::MaxRadius;
    if (bv > mur_abc_pkg::MaxRadius)  bv = mur_abc_pkg::MaxRadius;
    return mur_abc_pkg::AddrW'((av + mur_abc_pkg::MaxRadius) * mur_abc_pkg::PlaneSide
                               + bv + mur_abc_pkg::MaxRadius);
  endfunction

  // low face wins at radius zero
  function automatic mur_abc_pkg::face_sel_t classify(
    input logic signed [mur_abc_pkg::PosW-1:0] p,
    input logic signed [mur_abc_pkg::PosW-1:0] a,
    input logic signed [mur_abc_pkg::PosW-1:0] b,
    input logic signed [mur_abc_pkg::PosW:0]   rp,
    input logic signed [mur_abc_pkg::PosW:0]   rn);
    mur_abc_pkg::face_sel_t f;
    logic signed [mur_abc_pkg::PosW:0] pe;
    logic lo;
    pe     = {p[mur_abc_pkg::PosW-1], p};
    lo     = (pe == rn);
    f.high = !lo && (pe == rp);
    f.hit  = lo || f.high;
    f.addr = plane_index(a, b);
    return f;
  endfunction

  logic signed [mur_abc_pkg::PosW:0] rad_pos;
  logic signed [mur_abc_pkg::PosW:0] rad_neg;
  mur_abc_pkg::item_t                 item;
  logic                               push;

  mur_abc_pkg::item_t                 q_r [mur_abc_pkg::QDepth];
  logic [PtrW-1:0]                    wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]                    rd_ptr_r, rd_ptr_nxt;
  logic [mur_abc_pkg::LvlW-1:0]       level_r, level_nxt;

  assign rad_pos = signed'({{(mur_abc_pkg::PosW + 1 - mur_abc_pkg::RadW){1'b0}}, radius});
  assign rad_neg = -rad_pos;

  always_comb begin
    item.ex    = in_ex_here;
    item.ey    = in_ey_here;
    item.ez    = in_ez_here;
    item.ey_ix = in_ey_inner_x;
    item.ez_ix = in_ez_inner_x;
    item.ex_iy = in_ex_inner_y;
    item.ez_iy = in_ez_inner_y;
    item.ex_iz = in_ex_inner_z;
    item.ey_iz = in_ey_inner_z;
    item.fx    = classify(in_pos_x, in_pos_y, in_pos_z, rad_pos, rad_neg);
    item.fy    = classify(in_pos_y, in_pos_x, in_pos_z, rad_pos, rad_neg);
    item.fz    = classify(in_pos_z, in_pos_x, in_pos_y, rad_pos, rad_neg);
  end

  assign in_stall   = (level_r == mur_abc_pkg::LvlW'(mur_abc_pkg::QDepth));
  assign push       = in_valid && !in_stall;
  assign head_valid = (level_r != '0);
  assign head       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(mur_abc_pkg::QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(mur_abc_pkg::QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      level_nxt = level_r + 1'b1;
    end else if (pop && !push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

  assign stat.level = level_r;
  assign stat.full  = in_stall;

endmodule
`default_nettype wire

@@ rtl/mur_abc_back.sv @@
`default_nettype none
module mur_abc_back (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic signed [mur_abc_pkg::CoefW-1:0] coef,
  input  wire logic                                 head_valid,
  input  wire mur_abc_pkg::item_t                   head,
  output logic                                      pop,
  input  wire logic                                 out_stall,
  output logic                                      out_valid,
  output mur_abc_pkg::sample_t                      out_ex_new,
  output mur_abc_pkg::sample_t                      out_ey_new,
  output mur_abc_pkg::sample_t                      out_ez_new,
  output logic                                      out_not_on_boundary,
  output mur_abc_pkg::back_stat_t                   stat
);

  localparam int SW    = mur_abc_pkg::SampleW;
  localparam int FracW = mur_abc_pkg::CoefW - 1;
  localparam int ProdW = SW + 1 + mur_abc_pkg::CoefW;
  localparam int SumW  = ProdW + 2;
  localparam int NStg  = 6;
  localparam int AW    = mur_abc_pkg::AddrW;

  typedef logic signed [ProdW-1:0] prod_t;

  typedef struct packed {
    mur_abc_pkg::sample_t ex, ey, ez;
    mur_abc_pkg::sample_t ey_ix, ez_ix, ex_iy, ez_iy, ex_iz, ey_iz;
    logic                 hx, hy, hz;
    logic                 xh, yh, zh;
    mur_abc_pkg::sample_t oxa, oxb, oya, oyb, oza, ozb;
    prod_t                pa, pb;
  } pipe_t;

  function automatic prod_t mur_prod(input logic signed [mur_abc_pkg::CoefW-1:0] c,
                                     input mur_abc_pkg::sample_t inner,
                                     input mur_abc_pkg::sample_t cur);
    logic signed [SW:0] d;
    d = {inner[SW-1], inner} - {cur[SW-1], cur};
    return ProdW'(d) * ProdW'(c);
  endfunction

  // round half up, add stored value, saturate
  function automatic mur_abc_pkg::sample_t mur_fin(input mur_abc_pkg::sample_t old,
                                                   input prod_t p);
    logic signed [SumW-1:0] r;
    logic signed [SumW-1:0] s;
    r = SumW'(p) + SumW'(1 << (FracW - 1));
    s = (r >>> FracW) + SumW'(old);
    if (s[SumW-1:SW-1] == '0 || s[SumW-1:SW-1] == '1) begin
      return s[SW-1:0];
    end else if (s[SumW-1]) begin
      return {1'b1, {(SW-1){1'b0}}};
    end else begin
      return {1'b0, {(SW-1){1'b1}}};
    end
  endfunction

  logic              adv;
  logic              clr_r, clr_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;

  // face memories: x holds {Ez,Ey}, y {Ez,Ex}, z {Ey,Ex}
  logic [2*SW-1:0]   rd_xl, rd_xh, rd_yl, rd_yh, rd_zl, rd_zh;
  logic              en_xl, en_xh, en_yl, en_yh, en_zl, en_zh;
  logic [AW-1:0]     a_x, a_y, a_z;
  logic [2*SW-1:0]   wd_x, wd_y, wd_z;

  logic [NStg:1]     v_r;
  pipe_t             s1_r, s2_r, s3_r, s4_r, s5_r, s6_r;
  pipe_t             s1_nxt, s2_nxt, s3_nxt, s4_nxt, s5_nxt, s6_nxt;
  logic              out_valid_r;
  mur_abc_pkg::sample_t out_ex_r, out_ey_r, out_ez_r;
  logic              out_nb_r;
  mur_abc_pkg::sample_t fin_ex, fin_ey;

  assign adv = !out_valid_r || !out_stall;
  assign pop = head_valid && adv && !clr_r;

  assign en_xl = pop && head.fx.hit && !head.fx.high;
  assign en_xh = pop && head.fx.hit &&  head.fx.high;
  assign en_yl = pop && head.fy.hit && !head.fy.high;
  assign en_yh = pop && head.fy.hit &&  head.fy.high;
  assign en_zl = pop && head.fz.hit && !head.fz.high;
  assign en_zh = pop && head.fz.hit &&  head.fz.high;

  assign a_x  = clr_r ? clr_addr_r : head.fx.addr;
  assign a_y  = clr_r ? clr_addr_r : head.fy.addr;
  assign a_z  = clr_r ? clr_addr_r : head.fz.addr;
  assign wd_x = clr_r ? '0 : {head.ez_ix, head.ey_ix};
  assign wd_y = clr_r ? '0 : {head.ez_iy, head.ex_iy};
  assign wd_z = clr_r ? '0 : {head.ey_iz, head.ex_iz};

  mur_abc_face_ram u_ram_xl (.clk, .en(en_xl), .we(clr_r || en_xl), .addr(a_x),
                             .wdata(wd_x), .rdata(rd_xl));
  mur_abc_face_ram u_ram_xh (.clk, .en(en_xh), .we(clr_r || en_xh), .addr(a_x),
                             .wdata(wd_x), .rdata(rd_xh));
  mur_abc_face_ram u_ram_yl (.clk, .en(en_yl), .we(clr_r || en_yl), .addr(a_y),
                             .wdata(wd_y), .rdata(rd_yl));
  mur_abc_face_ram u_ram_yh (.clk, .en(en_yh), .we(clr_r || en_yh), .addr(a_y),
                             .wdata(wd_y), .rdata(rd_yh));
  mur_abc_face_ram u_ram_zl (.clk, .en(en_zl), .we(clr_r || en_zl), .addr(a_z),
                             .wdata(wd_z), .rdata(rd_zl));
  mur_abc_face_ram u_ram_zh (.clk, .en(en_zh), .we(clr_r || en_zh), .addr(a_z),
                             .wdata(wd_z), .rdata(rd_zh));

  // clearing sweep after reset
  always_comb begin
    clr_nxt      = clr_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_r) begin
      if (clr_addr_r == AW'(mur_abc_pkg::PlaneDepth - 1)) begin
        clr_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
    end
  end

  always_comb begin
    s1_nxt       = '0;
    s1_nxt.ex    = head.ex;
    s1_nxt.ey    = head.ey;
    s1_nxt.ez    = head.ez;
    s1_nxt.ey_ix = head.ey_ix;
    s1_nxt.ez_ix = head.ez_ix;
    s1_nxt.ex_iy = head.ex_iy;
    s1_nxt.ez_iy = head.ez_iy;
    s1_nxt.ex_iz = head.ex_iz;
    s1_nxt.ey_iz = head.ey_iz;
    s1_nxt.hx    = head.fx.hit;
    s1_nxt.hy    = head.fy.hit;
    s1_nxt.hz    = head.fz.hit;
    s1_nxt.xh    = head.fx.high;
    s1_nxt.yh    = head.fy.high;
    s1_nxt.zh    = head.fz.high;

    // capture stored pairs, x face products
    s2_nxt     = s1_r;
    {s2_nxt.oxb, s2_nxt.oxa} = s1_r.xh ? rd_xh : rd_xl;
    {s2_nxt.oyb, s2_nxt.oya} = s1_r.yh ? rd_yh : rd_yl;
    {s2_nxt.ozb, s2_nxt.oza} = s1_r.zh ? rd_zh : rd_zl;
    s2_nxt.pa  = mur_prod(coef, s1_r.ey_ix, s1_r.ey);
    s2_nxt.pb  = mur_prod(coef, s1_r.ez_ix, s1_r.ez);

    s3_nxt = s2_r;
    if (s2_r.hx) begin
      s3_nxt.ey = mur_fin(s2_r.oxa, s2_r.pa);
      s3_nxt.ez = mur_fin(s2_r.oxb, s2_r.pb);
    end

    s4_nxt    = s3_r;
    s4_nxt.pa = mur_prod(coef, s3_r.ex_iy, s3_r.ex);
    s4_nxt.pb = mur_prod(coef, s3_r.ez_iy, s3_r.ez);

    s5_nxt = s4_r;
    if (s4_r.hy) begin
      s5_nxt.ex = mur_fin(s4_r.oya, s4_r.pa);
      s5_nxt.ez = mur_fin(s4_r.oyb, s4_r.pb);
    end

    s6_nxt    = s5_r;
    s6_nxt.pa = mur_prod(coef, s5_r.ex_iz, s5_r.ex);
    s6_nxt.pb = mur_prod(coef, s5_r.ey_iz, s5_r.ey);

    fin_ex = s6_r.ex;
    fin_ey = s6_r.ey;
    if (s6_r.hz) begin
      fin_ex = mur_fin(s6_r.oza, s6_r.pa);
      fin_ey = mur_fin(s6_r.ozb, s6_r.pb);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= 1'b1;
      clr_addr_r  <= '0;
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_r      <= clr_nxt;
      clr_addr_r <= clr_addr_nxt;
      if (adv) begin
        v_r         <= {v_r[NStg-1:1], pop};
        out_valid_r <= v_r[NStg];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r     <= s1_nxt;
      s2_r     <= s2_nxt;
      s3_r     <= s3_nxt;
      s4_r     <= s4_nxt;
      s5_r     <= s5_nxt;
      s6_r     <= s6_nxt;
      out_ex_r <= fin_ex;
      out_ey_r <= fin_ey;
      out_ez_r <= s6_r.ez;
      out_nb_r <= !(s6_r.hx || s6_r.hy || s6_r.hz);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_ex_new          = out_ex_r;
  assign out_ey_new          = out_ey_r;
  assign out_ez_new          = out_ez_r;
  assign out_not_on_boundary = out_nb_r;
  assign stat.clearing       = clr_r;
  assign stat.busy           = (|v_r) || out_valid_r;

endmodule
`default_nettype wire

@@ rtl/mur_first_order_abc_update.sv @@
// First-order Mur absorbing boundary update, one boundary grid point per word.
//
// Input channel (in_valid / in_stall): point coordinates, the three E
// components at the point and the tangential components of its inward
// neighbors. Output channel (out_valid / out_stall): updated Ex, Ey, Ez
// (Q8.24, saturated) and not_on_boundary for a point on no face.
// Config port: cfg_we writes abc_coefficient (index 0, Q1.15) or
// boundary_radius (index 1); write only while the block is idle.
//
// Front: classifies faces, forms face addresses, and parks words in a
// 2-entry queue. Back: six face memories (read and written in the same
// cycle for each word, so no hazard between consecutive words) and a
// 6-stage pipe, one multiply stage and one round/saturate stage per axis,
// x then y then z. Throughput: one word per cycle while the output is not
// stalled and the clear is over. An accepted word passes through the queue,
// stages s1 to s6 and the output register. Reset: the face memories are
// cleared by a sweep through every address, one entry per cycle in all six
// memories; words queue up but are not started until it ends. Registers
// return to their reset values. Output stall: the whole back pipe freezes,
// the queue fills, and in_stall rises once it holds two words.
`default_nettype none
module mur_first_order_abc_update (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    cfg_we,
  input  wire logic [mur_abc_pkg::CfgIdxW-1:0]         cfg_index,
  input  wire logic [mur_abc_pkg::CoefW-1:0]           cfg_data,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic signed [mur_abc_pkg::PosW-1:0]     in_pos_x,
  input  wire logic signed [mur_abc_pkg::PosW-1:0]     in_pos_y,
  input  wire logic signed [mur_abc_pkg::PosW-1:0]     in_pos_z,
  input  wire mur_abc_pkg::sample_t                    in_ex_here,
  input  wire mur_abc_pkg::sample_t                    in_ey_here,
  input  wire mur_abc_pkg::sample_t                    in_ez_here,
  input  wire mur_abc_pkg::sample_t                    in_ey_inner_x,
  input  wire mur_abc_pkg::sample_t                    in_ez_inner_x,
  input  wire mur_abc_pkg::sample_t                    in_ex_inner_y,
  input  wire mur_abc_pkg::sample_t                    in_ez_inner_y,
  input  wire mur_abc_pkg::sample_t                    in_ex_inner_z,
  input  wire mur_abc_pkg::sample_t                    in_ey_inner_z,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output mur_abc_pkg::sample_t                         out_ex_new,
  output mur_abc_pkg::sample_t                         out_ey_new,
  output mur_abc_pkg::sample_t                         out_ez_new,
  output logic                                         out_not_on_boundary
);

  logic signed [mur_abc_pkg::CoefW-1:0] coef_r;
  logic [mur_abc_pkg::RadW-1:0]         radius_r;

  logic                      head_valid;
  mur_abc_pkg::item_t        head;
  logic                      pop;
  mur_abc_pkg::front_stat_t  front_stat;
  mur_abc_pkg::back_stat_t   back_stat;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r   <= mur_abc_pkg::CoefW'(-10923);
      radius_r <= mur_abc_pkg::RadW'(63);
    end else if (cfg_we) begin
      unique case (mur_abc_pkg::cfg_idx_t'(cfg_index))
        mur_abc_pkg::CfgCoef:   coef_r   <= cfg_data;
        mur_abc_pkg::CfgRadius: radius_r <= cfg_data[mur_abc_pkg::RadW-1:0];
        default:                coef_r   <= coef_r;
      endcase
    end
  end

  mur_abc_front u_front (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_pos_x, .in_pos_y, .in_pos_z,
    .in_ex_here, .in_ey_here, .in_ez_here,
    .in_ey_inner_x, .in_ez_inner_x, .in_ex_inner_y,
    .in_ez_inner_y, .in_ex_inner_z, .in_ey_inner_z,
    .radius(radius_r),
    .head_valid, .head, .pop,
    .stat(front_stat)
  );

  mur_abc_back u_back (
    .clk, .rst_n, .coef(coef_r),
    .head_valid, .head, .pop,
    .out_stall, .out_valid,
    .out_ex_new, .out_ey_new, .out_ez_new, .out_not_on_boundary,
    .stat(back_stat)
  );

  // nothing reaches the output while the face memories are being cleared
  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.clearing |-> !out_valid)
    else $error("output word during face memory clear");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    front_stat.level <= mur_abc_pkg::LvlW'(mur_abc_pkg::QDepth))
    else $error("front queue overfilled");

  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    front_stat.full |-> in_stall)
    else $error("full queue not stalling input");

  a_pop_not_clear: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.clearing |-> !pop)
    else $error("word started during face memory clear");

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mur_abc_pkg::*;

  localparam int SideN    = 2 * MaxRadius + 1;
  localparam int IdleLim  = 80000;   // covers the clearing sweep
  localparam int DrainLat = 16;      // pipeline latency plus margin

  // one point word as the driver presents it
  typedef struct {
    logic signed [PosW-1:0] px, py, pz;
    sample_t ex, ey, ez, eyix, ezix, exiy, eziy, exiz, eyiz;
  } point_t;

  typedef struct {
    sample_t ex, ey, ez;
    logic    off_face;
  } field_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CfgCoef;
  logic [CoefW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [PosW-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  sample_t in_ex_here = '0, in_ey_here = '0, in_ez_here = '0;
  sample_t in_ey_inner_x = '0, in_ez_inner_x = '0, in_ex_inner_y = '0;
  sample_t in_ez_inner_y = '0, in_ex_inner_z = '0, in_ey_inner_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sample_t out_ex_new, out_ey_new, out_ez_new;
  logic out_not_on_boundary;

  mur_first_order_abc_update dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state: six face memories, each entry {second, first}
  logic [63:0] mem_xl[SideN*SideN], mem_xh[SideN*SideN];
  logic [63:0] mem_yl[SideN*SideN], mem_yh[SideN*SideN];
  logic [63:0] mem_zl[SideN*SideN], mem_zh[SideN*SideN];
  logic signed [CoefW-1:0] p_coef = -16'sd10923;
  logic [RadW-1:0] p_radius = 6'd63;

  point_t pending_pts[$];
  field_t field_q[$];
  int     fail_cnt = 0;
  int     idle_cycles = 0;
  logic   took_in = 1'b0;

  function automatic int plane_addr(logic signed [PosW-1:0] a, logic signed [PosW-1:0] b);
    int ia, ib;
    ia = (a < -MaxRadius) ? -MaxRadius : (a > MaxRadius) ? MaxRadius : int'(a);
    ib = (b < -MaxRadius) ? -MaxRadius : (b > MaxRadius) ? MaxRadius : int'(b);
    return (ia + MaxRadius) * SideN + (ib + MaxRadius);
  endfunction

  // old + coef*(inner-cur) >>> 15 rounded half up, saturated to 32 bits
  function automatic sample_t mur_step(sample_t old, sample_t inner, sample_t cur);
    longint diff, prod, s;
    diff = longint'(inner) - longint'(cur);
    prod = longint'(p_coef) * diff + 64'sd16384;
    s = longint'(old) + (prod >>> 15);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return sample_t'(s);
  endfunction

  task automatic face_update(inout logic [63:0] ent, inout sample_t a, inout sample_t b,
                             input sample_t ia, input sample_t ib);
    a = mur_step(sample_t'(ent[31:0]), ia, a);
    b = mur_step(sample_t'(ent[63:32]), ib, b);
    ent = {ib, ia};
  endtask

  task automatic predict_fields(input point_t p);
    field_t f;
    int r, ad;
    bit hit;
    f.ex = p.ex; f.ey = p.ey; f.ez = p.ez;
    r = p_radius;
    hit = 0;
    if (p.px == -r) begin
      ad = plane_addr(p.py, p.pz); face_update(mem_xl[ad], f.ey, f.ez, p.eyix, p.ezix); hit = 1;
    end else if (p.px == r) begin
      ad = plane_addr(p.py, p.pz); face_update(mem_xh[ad], f.ey, f.ez, p.eyix, p.ezix); hit = 1;
    end
    if (p.py == -r) begin
      ad = plane_addr(p.px, p.pz); face_update(mem_yl[ad], f.ex, f.ez, p.exiy, p.eziy); hit = 1;
    end else if (p.py == r) begin
      ad = plane_addr(p.px, p.pz); face_update(mem_yh[ad], f.ex, f.ez, p.exiy, p.eziy); hit = 1;
    end
    if (p.pz == -r) begin
      ad = plane_addr(p.px, p.py); face_update(mem_zl[ad], f.ex, f.ey, p.exiz, p.eyiz); hit = 1;
    end else if (p.pz == r) begin
      ad = plane_addr(p.px, p.py); face_update(mem_zh[ad], f.ex, f.ey, p.exiz, p.eyiz); hit = 1;
    end
    f.off_face = !hit;
    field_q.push_back(f);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_cnt++;
  endtask

  // mostly short gaps, a few long ones, and some zero
  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // driver: present the head of the queue, advance on accept
  int drv_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || took_in) begin
        if (drv_gap > 0) begin
          drv_gap <= drv_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_pts.size() > 0) begin
          point_t p;
          p = pending_pts.pop_front();
          in_pos_x <= p.px; in_pos_y <= p.py; in_pos_z <= p.pz;
          in_ex_here <= p.ex; in_ey_here <= p.ey; in_ez_here <= p.ez;
          in_ey_inner_x <= p.eyix; in_ez_inner_x <= p.ezix;
          in_ex_inner_y <= p.exiy; in_ez_inner_y <= p.eziy;
          in_ex_inner_z <= p.exiz; in_ey_inner_z <= p.eyiz;
          in_valid <= 1'b1;
          drv_gap <= gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // sample handshakes at the rising edge
  always @(posedge clk) begin
    point_t p;
    field_t e;
    took_in <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      p.px = in_pos_x; p.py = in_pos_y; p.pz = in_pos_z;
      p.ex = in_ex_here; p.ey = in_ey_here; p.ez = in_ez_here;
      p.eyix = in_ey_inner_x; p.ezix = in_ez_inner_x;
      p.exiy = in_ex_inner_y; p.eziy = in_ez_inner_y;
      p.exiz = in_ex_inner_z; p.eyiz = in_ey_inner_z;
      predict_fields(p);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (field_q.size() == 0) begin
        report_mismatch("unexpected word", out_ex_new, '0);
      end else begin
        e = field_q.pop_front();
        if (out_ex_new !== e.ex) report_mismatch("ex_new", out_ex_new, e.ex);
        if (out_ey_new !== e.ey) report_mismatch("ey_new", out_ey_new, e.ey);
        if (out_ez_new !== e.ez) report_mismatch("ez_new", out_ez_new, e.ez);
        if (out_not_on_boundary !== e.off_face)
          report_mismatch("not_on_boundary", out_not_on_boundary, e.off_face);
      end
    end
    // watchdog: cycles with no word moving on either side
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLim) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver stall pattern
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left <= gap_len();
    end
  end

  function automatic logic signed [PosW-1:0] rand_pos();
    return PosW'($urandom_range(0, 126) - 63);
  endfunction

  function automatic sample_t rand_sample();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 32'sh7fffffff;
    if (k == 1) return 32'sh80000000;
    if (k < 5) return sample_t'($urandom_range(0, 8191)) - 32'sd4096;
    return sample_t'($urandom());
  endfunction

  function automatic point_t rand_point(logic signed [PosW-1:0] x, logic signed [PosW-1:0] y,
                                        logic signed [PosW-1:0] z);
    point_t p;
    p.px = x; p.py = y; p.pz = z;
    p.ex = rand_sample(); p.ey = rand_sample(); p.ez = rand_sample();
    p.eyix = rand_sample(); p.ezix = rand_sample(); p.exiy = rand_sample();
    p.eziy = rand_sample(); p.exiz = rand_sample(); p.eyiz = rand_sample();
    return p;
  endfunction

  // a coordinate that lands on a face, just outside the grid, or anywhere
  function automatic logic signed [PosW-1:0] face_coord(int r);
    int k;
    k = $urandom_range(0, 9);
    if (k < 3) return PosW'(-r);
    if (k < 6) return PosW'(r);
    if (k < 7) return PosW'($urandom_range(0, 1) ? 64 : -64);
    return rand_pos();
  endfunction

  // a point that revisits a small patch so face entries get reused
  function automatic point_t boundary_point(int r);
    logic signed [PosW-1:0] c[3];
    int ax;
    for (int i = 0; i < 3; i++) c[i] = ($urandom_range(0, 3) == 0) ? face_coord(r)
                                       : PosW'($urandom_range(0, 4) - 2);
    ax = $urandom_range(0, 2);
    c[ax] = $urandom_range(0, 1) ? PosW'(r) : PosW'(-r);
    return rand_point(c[0], c[1], c[2]);
  endfunction

  task automatic wait_idle();
    while (pending_pts.size() > 0 || field_q.size() > 0 || in_valid) @(posedge clk);
    repeat (DrainLat) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CoefW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgCoef) p_coef = val;
    else p_radius = val[RadW-1:0];
  endtask

  initial begin
    logic [CoefW-1:0] coefs[6];
    logic [RadW-1:0] radii[6];
    for (int i = 0; i < SideN * SideN; i++) begin
      mem_xl[i] = '0; mem_xh[i] = '0; mem_yl[i] = '0;
      mem_yh[i] = '0; mem_zl[i] = '0; mem_zh[i] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: corners, edges, no face, out-of-grid coordinates
    pending_pts.push_back(rand_point(-63, -63, -63));
    pending_pts.push_back(rand_point(63, 63, 63));
    pending_pts.push_back(rand_point(-63, 63, 0));
    pending_pts.push_back(rand_point(0, 0, 0));
    pending_pts.push_back(rand_point(-64, 5, 63));
    pending_pts.push_back(rand_point(63, -64, -64));
    pending_pts.push_back(rand_point(-63, -63, -63));
    pending_pts.push_back(rand_point(63, 63, 63));
    begin
      point_t p;
      p = rand_point(-63, 0, 0);
      p.ey = 32'sh80000000; p.eyix = 32'sh7fffffff; p.ez = 32'sh7fffffff; p.ezix = 32'sh80000000;
      pending_pts.push_back(p);
      pending_pts.push_back(p);
    end
    wait_idle();

    // settings: coefficient extremes, positive coefficient, radius zero and extremes
    coefs = '{16'h8000, 16'h0000, 16'h7fff, 16'hd555, 16'hffff, 16'h4000};
    radii = '{6'd1, 6'd63, 6'd0, 6'd2, 6'd40, 6'd63};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CfgCoef, coefs[ph]);
      write_reg(CfgRadius, radii[ph]);
      for (int n = 0; n < 265; n++) begin
        if ($urandom_range(0, 9) < 8) pending_pts.push_back(boundary_point(radii[ph]));
        else pending_pts.push_back(rand_point(rand_pos(), rand_pos(), rand_pos()));
      end
      wait_idle();
    end

    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
rtl/mur_abc_pkg.sv
rtl/mur_abc_face_ram.sv
rtl/mur_abc_front.sv
rtl/mur_abc_back.sv
rtl/mur_first_order_abc_update.sv
dv/tb_top.sv
